// ===== design/lobu_pkg.sv =====
// shared types and constants for the limit order book update core
`timescale 1ns / 1ps
package lobu_pkg;

   localparam int ORDER_SLOTS_DEF = 1024;
   localparam int LEVEL_SLOTS_DEF = 256;

   localparam int REF_W      = 64;
   localparam int PRICE_W    = 32;
   localparam int QTY_W      = 32;
   localparam int REQ_DATA_W = 248;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 4;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_EXEC    = 3'd1,
      OP_DELETE  = 3'd2,
      OP_REPLACE = 3'd3,
      OP_CLOCK   = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      STS_OK           = 4'd0,
      STS_BAD_SIDE     = 4'd1,
      STS_ZERO_PRICE   = 4'd2,
      STS_ZERO_QTY     = 4'd3,
      STS_DUPLICATE    = 4'd4,
      STS_NOT_FOUND    = 4'd5,
      STS_EXCEEDS      = 4'd6,
      STS_OVERFLOW     = 4'd7,
      STS_INCONSISTENT = 4'd8,
      STS_FULL         = 4'd9
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [REF_W-1:0]    order_ref;
      logic [REF_W-1:0]    new_order_ref;
      logic [1:0]          side;
      logic [PRICE_W-1:0]  price;
      logic [QTY_W-1:0]    qty;
      status_type          pre_status;
   } item_type;

   typedef struct packed {
      logic                valid;
      logic [REF_W-1:0]    key;
      logic                side;
      logic [PRICE_W-1:0]  price;
      logic [QTY_W-1:0]    shares;
   } order_entry_type;

   typedef struct packed {
      logic                valid;
      logic [PRICE_W-1:0]  price;
      logic [QTY_W-1:0]    qty;
   } level_entry_type;

endpackage

// ===== design/lobu_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module lobu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/lobu_front.sv =====
// front end: accepts messages, classifies them and queues them for the engine
`timescale 1ns / 1ps
module lobu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // order_ref, new_order_ref, side, limit price, quantity, timestamp_ns, zero pad
   input  logic [lobu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic [lobu_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             q_valid,
   output lobu_pkg::item_type               q_item,
   input  logic                             q_pop
);
   import lobu_pkg::*;

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   dec;
   logic       push;

   always_comb begin
      dec.order_ref     = req_tdata[63:0];
      dec.new_order_ref = req_tdata[127:64];
      dec.side          = req_tdata[129:128];
      dec.price         = req_tdata[161:130];
      dec.qty           = req_tdata[193:162];
      unique case (req_tuser)
         OP_ADD:     dec.op = OP_ADD;
         OP_EXEC:    dec.op = OP_EXEC;
         OP_DELETE:  dec.op = OP_DELETE;
         OP_REPLACE: dec.op = OP_REPLACE;
         default:    dec.op = OP_CLOCK;
      endcase
      // stateless checks of an add
      priority if (dec.side[1]) begin
         dec.pre_status = STS_BAD_SIDE;
      end else if (dec.price == '0) begin
         dec.pre_status = STS_ZERO_PRICE;
      end else if (dec.qty == '0) begin
         dec.pre_status = STS_ZERO_QTY;
      end else begin
         dec.pre_status = STS_OK;
      end
   end

   assign req_tready = enable && (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = q_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = ~wptr_ff;
      end
      if (q_pop) begin
         rptr_in = ~rptr_ff;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= dec;
      end
   end

endmodule

// ===== design/lobu_back.sv =====
// back end: table scans, checks, commit and top-of-book scan
`timescale 1ns / 1ps
module lobu_back #(
   parameter int ORDER_SLOTS = lobu_pkg::ORDER_SLOTS_DEF,
   parameter int LEVEL_SLOTS = lobu_pkg::LEVEL_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  lobu_pkg::item_type               q_item,
   output logic                             q_pop,
   output logic                             ready_for_items,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lobu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [lobu_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import lobu_pkg::*;

   localparam int OW    = $clog2(ORDER_SLOTS);
   localparam int LW    = $clog2(LEVEL_SLOTS);
   // each side takes a power-of-two half of the level memory
   localparam int LVL_D = 2 * (1 << LW);
   localparam int CLR_N = (ORDER_SLOTS > LVL_D) ? ORDER_SLOTS : LVL_D;
   localparam int CW    = $clog2(CLR_N) + 1;
   localparam logic [CW-1:0] ORD_N  = CW'(ORDER_SLOTS);
   localparam logic [CW-1:0] LVLH_N = CW'(LEVEL_SLOTS);
   localparam logic [CW-1:0] LVL_N  = CW'(LVL_D);
   localparam logic [CW-1:0] CLR_L  = CW'(CLR_N - 1);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_OSCAN = 8'b0000_0100,
      S_LSCAN = 8'b0000_1000,
      S_EVAL  = 8'b0001_0000,
      S_WR2   = 8'b0010_0000,
      S_BSCAN = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  pv_ff, pv_in;
   logic [CW-1:0]         pidx_ff, pidx_in;
   item_type              item_ff, item_in;
   logic                  fo_ff, fo_in;
   logic [OW-1:0]         fo_idx_ff, fo_idx_in;
   logic                  o_side_ff, o_side_in;
   logic [PRICE_W-1:0]    o_price_ff, o_price_in;
   logic [QTY_W-1:0]      o_shares_ff, o_shares_in;
   logic                  fn_ff, fn_in;
   logic                  of_ff, of_in;
   logic [OW-1:0]         of_idx_ff, of_idx_in;
   logic                  la_ff, la_in;
   logic [LW-1:0]         la_idx_ff, la_idx_in;
   logic [QTY_W-1:0]      la_qty_ff, la_qty_in;
   logic                  lb_ff, lb_in;
   logic [LW-1:0]         lb_idx_ff, lb_idx_in;
   logic [QTY_W-1:0]      lb_qty_ff, lb_qty_in;
   logic                  lf_ff, lf_in;
   logic [LW-1:0]         lf_idx_ff, lf_idx_in;
   logic [LW-1:0]         l2_idx_ff, l2_idx_in;
   level_entry_type       l2_data_ff, l2_data_in;
   status_type            status_ff, status_in;
   logic                  bbv_ff, bbv_in;
   logic [PRICE_W-1:0]    bb_ff, bb_in;
   logic                  bav_ff, bav_in;
   logic [PRICE_W-1:0]    ba_ff, ba_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // memory ports
   logic                        o_we;
   logic [OW-1:0]               o_waddr, o_raddr;
   logic [$bits(order_entry_type)-1:0] o_wdata, o_rdata;
   logic                        l_we;
   logic [LW:0]                 l_waddr, l_raddr;
   logic [$bits(level_entry_type)-1:0] l_wdata, l_rdata;
   order_entry_type             oe;
   level_entry_type             le;

   // evaluation
   logic                  lvl_side;
   logic [PRICE_W-1:0]    lvl_pa;
   logic [QTY_W-1:0]      amt, nq, rem, base;
   logic [QTY_W:0]        sum_a, sum_r;
   logic                  same, nl_found;
   logic [LW-1:0]         nl_idx;
   status_type            ev_status;
   logic                  ev_ow_en;
   logic [OW-1:0]         ev_ow_idx;
   order_entry_type       ev_ow_data;
   logic                  ev_l1_en;
   logic [LW-1:0]         ev_l1_idx;
   level_entry_type       ev_l1_data;
   logic                  ev_l2_en;
   logic [LW-1:0]         ev_l2_idx;
   level_entry_type       ev_l2_data;

   // scan control and result
   logic                  scan_state, issue;
   logic [CW-1:0]         limit;
   logic [PRICE_W-1:0]    lo, hi, mid;
   logic                  midv;

   lobu_ram #(.WIDTH($bits(order_entry_type)), .DEPTH(ORDER_SLOTS)) u_order_ram (
      .clock (clock),
      .we    (o_we),
      .waddr (o_waddr),
      .wdata (o_wdata),
      .raddr (o_raddr),
      .rdata (o_rdata)
   );

   lobu_ram #(.WIDTH($bits(level_entry_type)), .DEPTH(LVL_D)) u_level_ram (
      .clock (clock),
      .we    (l_we),
      .waddr (l_waddr),
      .wdata (l_wdata),
      .raddr (l_raddr),
      .rdata (l_rdata)
   );

   assign oe = order_entry_type'(o_rdata);
   assign le = level_entry_type'(l_rdata);

   assign lvl_side = (item_ff.op == OP_ADD) ? item_ff.side[0] : o_side_ff;
   assign lvl_pa   = (item_ff.op == OP_ADD) ? item_ff.price : o_price_ff;

   // checks and commit data
   always_comb begin
      amt      = (item_ff.op == OP_DELETE) ? o_shares_ff : item_ff.qty;
      nq       = (la_qty_ff > amt) ? (la_qty_ff - amt) : '0;
      rem      = la_qty_ff - o_shares_ff;
      same     = (item_ff.price == o_price_ff);
      base     = same ? rem : (lb_ff ? lb_qty_ff : '0);
      sum_a    = {1'b0, (la_ff ? la_qty_ff : '0)} + {1'b0, item_ff.qty};
      sum_r    = {1'b0, base} + {1'b0, item_ff.qty};
      nl_found = same || lb_ff;
      nl_idx   = nl_found ? (same ? la_idx_ff : lb_idx_ff)
                          : ((rem == '0) ? la_idx_ff : lf_idx_ff);

      ev_status  = STS_OK;
      ev_ow_en   = 1'b0;
      ev_ow_idx  = fo_idx_ff;
      ev_ow_data = '0;
      ev_l1_en   = 1'b0;
      ev_l1_idx  = la_idx_ff;
      ev_l1_data = '0;
      ev_l2_en   = 1'b0;
      ev_l2_idx  = nl_idx;
      ev_l2_data = '0;

      unique case (item_ff.op)
         OP_ADD: begin
            priority if (item_ff.pre_status != STS_OK) begin
               ev_status = item_ff.pre_status;
            end else if (fo_ff) begin
               ev_status = STS_DUPLICATE;
            end else if (sum_a[QTY_W]) begin
               ev_status = STS_OVERFLOW;
            end else if (!of_ff || (!la_ff && !lf_ff)) begin
               ev_status = STS_FULL;
            end else begin
               ev_ow_en   = 1'b1;
               ev_ow_idx  = of_idx_ff;
               ev_ow_data = '{valid: 1'b1, key: item_ff.order_ref, side: item_ff.side[0],
                              price: item_ff.price, shares: item_ff.qty};
               ev_l1_en   = 1'b1;
               ev_l1_idx  = la_ff ? la_idx_ff : lf_idx_ff;
               ev_l1_data = '{valid: 1'b1, price: item_ff.price, qty: sum_a[QTY_W-1:0]};
            end
         end
         OP_EXEC, OP_DELETE: begin
            priority if (!fo_ff) begin
               ev_status = STS_NOT_FOUND;
            end else if (amt == '0) begin
               ev_status = STS_ZERO_QTY;
            end else if (amt > o_shares_ff) begin
               ev_status = STS_EXCEEDS;
            end else begin
               ev_l1_en   = la_ff;
               ev_l1_data = '{valid: (nq != '0), price: o_price_ff, qty: nq};
               ev_ow_en   = 1'b1;
               ev_ow_data = '{valid: (amt != o_shares_ff), key: item_ff.order_ref,
                              side: o_side_ff, price: o_price_ff,
                              shares: o_shares_ff - amt};
            end
         end
         OP_REPLACE: begin
            priority if (!fo_ff) begin
               ev_status = STS_NOT_FOUND;
            end else if ((item_ff.new_order_ref != item_ff.order_ref) && fn_ff) begin
               ev_status = STS_DUPLICATE;
            end else if (item_ff.price == '0) begin
               ev_status = STS_ZERO_PRICE;
            end else if (item_ff.qty == '0) begin
               ev_status = STS_ZERO_QTY;
            end else if (!la_ff) begin
               ev_status = STS_INCONSISTENT;
            end else if (la_qty_ff < o_shares_ff) begin
               ev_status = STS_OVERFLOW;
            end else if (sum_r[QTY_W]) begin
               ev_status = STS_OVERFLOW;
            end else if (!nl_found && (rem != '0) && !lf_ff) begin
               ev_status = STS_FULL;
            end else begin
               ev_ow_en   = 1'b1;
               ev_ow_data = '{valid: 1'b1, key: item_ff.new_order_ref, side: o_side_ff,
                              price: item_ff.price, shares: item_ff.qty};
               ev_l1_en   = 1'b1;
               if (nl_idx != la_idx_ff) begin
                  ev_l1_data = '{valid: (rem != '0), price: o_price_ff, qty: rem};
                  ev_l2_en   = 1'b1;
                  ev_l2_data = '{valid: 1'b1, price: item_ff.price,
                                 qty: sum_r[QTY_W-1:0]};
               end else begin
                  ev_l1_data = '{valid: 1'b1, price: item_ff.price,
                                 qty: sum_r[QTY_W-1:0]};
               end
            end
         end
         default: ev_status = STS_OK;
      endcase
   end

   // memory port selection
   always_comb begin
      o_we    = 1'b0;
      o_waddr = ev_ow_idx;
      o_wdata = ev_ow_data;
      o_raddr = cnt_ff[OW-1:0];
      l_we    = 1'b0;
      l_waddr = {lvl_side, ev_l1_idx};
      l_wdata = ev_l1_data;
      l_raddr = (state_ff == S_BSCAN) ? cnt_ff[LW:0] : {lvl_side, cnt_ff[LW-1:0]};
      unique case (state_ff)
         S_CLEAR: begin
            o_we    = (cnt_ff < ORD_N);
            o_waddr = cnt_ff[OW-1:0];
            o_wdata = '0;
            l_we    = (cnt_ff < LVL_N);
            l_waddr = cnt_ff[LW:0];
            l_wdata = '0;
         end
         S_EVAL: begin
            o_we = ev_ow_en;
            l_we = ev_l1_en;
         end
         S_WR2: begin
            l_we    = 1'b1;
            l_waddr = {lvl_side, l2_idx_ff};
            l_wdata = l2_data_ff;
         end
         default: begin
            o_we = 1'b0;
            l_we = 1'b0;
         end
      endcase
   end

   // midpoint of the book
   always_comb begin
      lo   = (bb_ff < ba_ff) ? bb_ff : ba_ff;
      hi   = (bb_ff < ba_ff) ? ba_ff : bb_ff;
      mid  = lo + ((hi - lo) >> 1);
      midv = bbv_ff && bav_ff && (mid != '0);
   end

   assign scan_state = (state_ff == S_OSCAN) || (state_ff == S_LSCAN) ||
                       (state_ff == S_BSCAN);

   always_comb begin
      unique case (state_ff)
         S_OSCAN: limit = ORD_N;
         S_LSCAN: limit = LVLH_N;
         default: limit = LVL_N;
      endcase
   end

   assign issue = scan_state && (cnt_ff < limit);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pv_in        = issue;
      pidx_in      = cnt_ff;
      item_in      = item_ff;
      fo_in        = fo_ff;
      fo_idx_in    = fo_idx_ff;
      o_side_in    = o_side_ff;
      o_price_in   = o_price_ff;
      o_shares_in  = o_shares_ff;
      fn_in        = fn_ff;
      of_in        = of_ff;
      of_idx_in    = of_idx_ff;
      la_in        = la_ff;
      la_idx_in    = la_idx_ff;
      la_qty_in    = la_qty_ff;
      lb_in        = lb_ff;
      lb_idx_in    = lb_idx_ff;
      lb_qty_in    = lb_qty_ff;
      lf_in        = lf_ff;
      lf_idx_in    = lf_idx_ff;
      l2_idx_in    = l2_idx_ff;
      l2_data_in   = l2_data_ff;
      status_in    = status_ff;
      bbv_in       = bbv_ff;
      bb_in        = bb_ff;
      bav_in       = bav_ff;
      ba_in        = ba_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      q_pop        = 1'b0;

      if (issue) begin
         cnt_in = cnt_ff + CW'(1);
      end

      // scan data arrives in the cycle after its address is issued
      if (pv_ff) begin
         unique case (state_ff)
            S_OSCAN: begin
               if (oe.valid && (oe.key == item_ff.order_ref) && !fo_ff) begin
                  fo_in       = 1'b1;
                  fo_idx_in   = pidx_ff[OW-1:0];
                  o_side_in   = oe.side;
                  o_price_in  = oe.price;
                  o_shares_in = oe.shares;
               end
               if (oe.valid && (oe.key == item_ff.new_order_ref)) begin
                  fn_in = 1'b1;
               end
               if (!oe.valid && !of_ff) begin
                  of_in     = 1'b1;
                  of_idx_in = pidx_ff[OW-1:0];
               end
            end
            S_LSCAN: begin
               if (le.valid && (le.price == lvl_pa) && !la_ff) begin
                  la_in     = 1'b1;
                  la_idx_in = pidx_ff[LW-1:0];
                  la_qty_in = le.qty;
               end
               if (le.valid && (le.price == item_ff.price) && !lb_ff) begin
                  lb_in     = 1'b1;
                  lb_idx_in = pidx_ff[LW-1:0];
                  lb_qty_in = le.qty;
               end
               if (!le.valid && !lf_ff) begin
                  lf_in     = 1'b1;
                  lf_idx_in = pidx_ff[LW-1:0];
               end
            end
            S_BSCAN: begin
               if (le.valid && !pidx_ff[LW] && (!bbv_ff || (le.price > bb_ff))) begin
                  bbv_in = 1'b1;
                  bb_in  = le.price;
               end
               if (le.valid && pidx_ff[LW] && (!bav_ff || (le.price < ba_ff))) begin
                  bav_in = 1'b1;
                  ba_in  = le.price;
               end
            end
            default: begin
               bbv_in = bbv_ff;
            end
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CLR_L) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               cnt_in    = '0;
               fo_in     = 1'b0;
               fn_in     = 1'b0;
               of_in     = 1'b0;
               la_in     = 1'b0;
               lb_in     = 1'b0;
               lf_in     = 1'b0;
               bbv_in    = 1'b0;
               bb_in     = '0;
               bav_in    = 1'b0;
               ba_in     = '0;
               status_in = STS_OK;
               state_in  = (q_item.op == OP_CLOCK) ? S_BSCAN : S_OSCAN;
            end
         end
         S_OSCAN, S_LSCAN, S_BSCAN: begin
            if (!issue && !pv_ff) begin
               cnt_in = '0;
               unique case (state_ff)
                  S_OSCAN: state_in = S_LSCAN;
                  S_LSCAN: state_in = S_EVAL;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_EVAL: begin
            status_in  = ev_status;
            l2_idx_in  = ev_l2_idx;
            l2_data_in = ev_l2_data;
            state_in   = ev_l2_en ? S_WR2 : S_BSCAN;
         end
         S_WR2: begin
            state_in = S_BSCAN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, midv, (midv ? mid : '0), bav_ff, ba_ff,
                               bbv_ff, bb_ff};
               rsp_user_in  = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         item_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      fo_ff       <= fo_in;
      fo_idx_ff   <= fo_idx_in;
      o_side_ff   <= o_side_in;
      o_price_ff  <= o_price_in;
      o_shares_ff <= o_shares_in;
      fn_ff       <= fn_in;
      of_ff       <= of_in;
      of_idx_ff   <= of_idx_in;
      la_ff       <= la_in;
      la_idx_ff   <= la_idx_in;
      la_qty_ff   <= la_qty_in;
      lb_ff       <= lb_in;
      lb_idx_ff   <= lb_idx_in;
      lb_qty_ff   <= lb_qty_in;
      lf_ff       <= lf_in;
      lf_idx_ff   <= lf_idx_in;
      l2_idx_ff   <= l2_idx_in;
      l2_data_ff  <= l2_data_in;
      status_ff   <= status_in;
      bbv_ff      <= bbv_in;
      bb_ff       <= bb_in;
      bav_ff      <= bav_in;
      ba_ff       <= ba_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign ready_for_items = (state_ff != S_CLEAR);
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;

endmodule

// ===== design/limit_order_book_update_core.sv =====
// top level of the limit order book update core
//
// One market-data message enters per transfer on the req_ channel (op in
// req_tuser, the other fields in req_tdata); each message gives exactly one
// result transfer on the rsp_ channel: status in rsp_tuser, top bid, top
// ask and midpoint in rsp_tdata, as the book stands after the message.
// A two-entry queue sits between the front end and the table engine.
// The engine handles one message at a time, scanning its tables held in
// block memories one entry per cycle through the read port:
//   queue pop, order scan over ORDER_SLOTS entries, level scan over the
//   LEVEL_SLOTS entries of the message's side, evaluation and commit with
//   an optional second level write, then a top-of-book scan over all
//   2 * 2**clog2(LEVEL_SLOTS) level entries and the result load;
//   clock-only messages skip both table scans and the evaluation.
// After reset the memories are cleared with req_tready low. A result waits in
// the output register while rsp_tready is low; the engine goes on with the
// next message but holds before loading its result until the register is
// free, and the queue keeps taking messages until both entries are full.
`timescale 1ns / 1ps
module limit_order_book_update_core #(
   parameter int ORDER_SLOTS = lobu_pkg::ORDER_SLOTS_DEF,
   parameter int LEVEL_SLOTS = lobu_pkg::LEVEL_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // order_ref, new_order_ref, side, limit price, quantity, timestamp_ns, zero pad
   input  logic [lobu_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic [lobu_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // top bid, top bid valid, top ask, top ask valid, midpoint, midpoint valid, zero pad
   output logic [lobu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [lobu_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import lobu_pkg::*;

   logic     q_valid;
   item_type q_item;
   logic     q_pop;
   logic     ready_for_items;

   lobu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (ready_for_items),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   lobu_back #(
      .ORDER_SLOTS (ORDER_SLOTS),
      .LEVEL_SLOTS (LEVEL_SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .ready_for_items (ready_for_items),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser)
   );

endmodule

// ===== verif/tb_limit_order_book_update_core.sv =====
// testbench for the limit order book update core: directed table, random feed, book fill
`timescale 1ns / 1ps
module tb_limit_order_book_update_core;
   import lobu_pkg::*;

   localparam int NORD = ORDER_SLOTS_DEF;
   localparam int NLVL = LEVEL_SLOTS_DEF;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] oref;
      logic [63:0] nref;
      logic [1:0]  side;
      logic [31:0] price;
      logic [31:0] qty;
      logic [47:0] ts;
   } msg_type;

   typedef struct {
      status_type  st;
      logic [31:0] bb;
      logic        bbv;
      logic [31:0] ba;
      logic        bav;
      logic [31:0] mid;
      logic        midv;
   } book_type;

   typedef struct {
      msg_type    m;
      bit         typed;
      status_type st;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   limit_order_book_update_core dut (.*);

   always #2 clock = ~clock;

   // predictor state
   bit          ord_v[NORD];
   logic [63:0] ord_key[NORD];
   bit          ord_side[NORD];
   logic [31:0] ord_price[NORD];
   logic [31:0] ord_shares[NORD];
   bit          lvl_v[2][NLVL];
   logic [31:0] lvl_price[2][NLVL];
   logic [31:0] lvl_qty[2][NLVL];

   book_type expected_books[$];
   int errors = 0;
   int checked = 0;
   int sent = 0;
   int full_seen = 0;
   int ok_seen = 0;

   function automatic int find_order(logic [63:0] k);
      for (int i = 0; i < NORD; i++) if (ord_v[i] && ord_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int free_order();
      for (int i = 0; i < NORD; i++) if (!ord_v[i]) return i;
      return -1;
   endfunction

   function automatic int find_level(bit s, logic [31:0] p);
      for (int i = 0; i < NLVL; i++) if (lvl_v[s][i] && lvl_price[s][i] == p) return i;
      return -1;
   endfunction

   function automatic int free_level(bit s);
      for (int i = 0; i < NLVL; i++) if (!lvl_v[s][i]) return i;
      return -1;
   endfunction

   function automatic status_type enter_order(msg_type m);
      int l, o;
      bit s;
      logic [32:0] sum;
      if (m.side > 1) return STS_BAD_SIDE;
      if (m.price == 0) return STS_ZERO_PRICE;
      if (m.qty == 0) return STS_ZERO_QTY;
      if (find_order(m.oref) >= 0) return STS_DUPLICATE;
      s = m.side[0];
      l = find_level(s, m.price);
      sum = (l >= 0 ? {1'b0, lvl_qty[s][l]} : 33'd0) + {1'b0, m.qty};
      if (sum[32]) return STS_OVERFLOW;
      o = free_order();
      if (o < 0) return STS_FULL;
      if (l < 0) begin
         l = free_level(s);
         if (l < 0) return STS_FULL;
         lvl_v[s][l] = 1;
         lvl_price[s][l] = m.price;
      end
      lvl_qty[s][l] = sum[31:0];
      ord_v[o] = 1;
      ord_key[o] = m.oref;
      ord_side[o] = s;
      ord_price[o] = m.price;
      ord_shares[o] = m.qty;
      return STS_OK;
   endfunction

   function automatic status_type reduce_order(int o, logic [31:0] amt);
      int l;
      bit s;
      if (amt == 0) return STS_ZERO_QTY;
      if (amt > ord_shares[o]) return STS_EXCEEDS;
      s = ord_side[o];
      l = find_level(s, ord_price[o]);
      if (l >= 0) begin
         lvl_qty[s][l] = lvl_qty[s][l] > amt ? lvl_qty[s][l] - amt : 32'd0;
         if (lvl_qty[s][l] == 0) lvl_v[s][l] = 0;
      end
      if (amt == ord_shares[o]) ord_v[o] = 0;
      else ord_shares[o] -= amt;
      return STS_OK;
   endfunction

   function automatic status_type modify_order(msg_type m);
      int o, ol, nl;
      bit s;
      logic [31:0] rem, base;
      logic [32:0] sum;
      o = find_order(m.oref);
      if (o < 0) return STS_NOT_FOUND;
      if (m.nref != m.oref && find_order(m.nref) >= 0) return STS_DUPLICATE;
      if (m.price == 0) return STS_ZERO_PRICE;
      if (m.qty == 0) return STS_ZERO_QTY;
      s = ord_side[o];
      ol = find_level(s, ord_price[o]);
      if (ol < 0) return STS_INCONSISTENT;
      if (lvl_qty[s][ol] < ord_shares[o]) return STS_OVERFLOW;
      rem = lvl_qty[s][ol] - ord_shares[o];
      if (m.price == ord_price[o]) begin
         nl = ol;
         base = rem;
      end else begin
         nl = find_level(s, m.price);
         base = nl >= 0 ? lvl_qty[s][nl] : 32'd0;
      end
      sum = {1'b0, base} + {1'b0, m.qty};
      if (sum[32]) return STS_OVERFLOW;
      if (nl < 0) begin
         nl = (rem == 0) ? ol : free_level(s);
         if (nl < 0) return STS_FULL;
      end
      if (nl != ol) begin
         if (rem == 0) lvl_v[s][ol] = 0;
         else lvl_qty[s][ol] = rem;
      end
      lvl_v[s][nl] = 1;
      lvl_price[s][nl] = m.price;
      lvl_qty[s][nl] = sum[31:0];
      ord_key[o] = m.nref;
      ord_price[o] = m.price;
      ord_shares[o] = m.qty;
      return STS_OK;
   endfunction

   function automatic book_type predict_message(msg_type m);
      book_type r;
      int o;
      logic [31:0] lo, hi;
      r = '{STS_OK, 0, 0, 0, 0, 0, 0};
      case (m.op)
         OP_ADD: r.st = enter_order(m);
         OP_EXEC: begin
            o = find_order(m.oref);
            r.st = (o < 0) ? STS_NOT_FOUND : reduce_order(o, m.qty);
         end
         OP_DELETE: begin
            o = find_order(m.oref);
            r.st = (o < 0) ? STS_NOT_FOUND : reduce_order(o, ord_shares[o]);
         end
         OP_REPLACE: r.st = modify_order(m);
         default: r.st = STS_OK;
      endcase
      for (int i = 0; i < NLVL; i++) begin
         if (lvl_v[0][i] && (!r.bbv || lvl_price[0][i] > r.bb)) begin
            r.bb = lvl_price[0][i];
            r.bbv = 1;
         end
         if (lvl_v[1][i] && (!r.bav || lvl_price[1][i] < r.ba)) begin
            r.ba = lvl_price[1][i];
            r.bav = 1;
         end
      end
      if (r.bbv && r.bav) begin
         lo = r.bb < r.ba ? r.bb : r.ba;
         hi = r.bb < r.ba ? r.ba : r.bb;
         r.mid = lo + (hi - lo) / 2;
         r.midv = (r.mid != 0);
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_message(msg_type m, bit typed, status_type st);
      book_type r;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = m.op;
      req_tdata = {6'd0, m.ts, m.qty, m.price, m.side, m.nref, m.oref};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      r = predict_message(m);
      if (typed) r = '{st, 0, 0, 0, 0, 0, 0};
      expected_books.push_back(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
   endtask

   // result stall pattern
   int stall = 0;
   always @(negedge clock) begin
      if (stall > 0) begin
         stall--;
         rsp_tready <= 0;
      end else begin
         stall = pick_gap();
         rsp_tready <= (stall == 0);
      end
   end

   always @(posedge clock) begin
      book_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_books.size() == 0) begin
            report("unexpected result status", 32'(rsp_tuser), '0);
         end else begin
            e = expected_books.pop_front();
            if (rsp_tuser != e.st) report("status", 32'(rsp_tuser), 32'(e.st));
            if (rsp_tdata[31:0] != e.bb) report("top bid", rsp_tdata[31:0], e.bb);
            if (rsp_tdata[32] != e.bbv)
               report("top bid valid", 32'(rsp_tdata[32]), 32'(e.bbv));
            if (rsp_tdata[64:33] != e.ba) report("top ask", rsp_tdata[64:33], e.ba);
            if (rsp_tdata[65] != e.bav)
               report("top ask valid", 32'(rsp_tdata[65]), 32'(e.bav));
            if (rsp_tdata[97:66] != e.mid) report("midpoint", rsp_tdata[97:66], e.mid);
            if (rsp_tdata[98] != e.midv)
               report("midpoint valid", 32'(rsp_tdata[98]), 32'(e.midv));
            if (e.st == STS_FULL) full_seen++;
            if (e.st == STS_OK) ok_seen++;
            checked++;
         end
      end
   end

   function automatic logic [63:0] pick_ref();
      int start;
      if ($urandom_range(0, 9) < 8) begin
         start = $urandom_range(0, NORD - 1);
         for (int i = 0; i < NORD; i++)
            if (ord_v[(start + i) % NORD]) return ord_key[(start + i) % NORD];
      end
      return {$urandom, $urandom};
   endfunction

   function automatic msg_type random_message();
      msg_type m;
      int k;
      m.op = op_type'($urandom_range(0, 4));
      if ($urandom_range(0, 19) == 0) m.op = 3'($urandom_range(5, 7));
      m.oref = (m.op == OP_ADD && $urandom_range(0, 3) != 0) ? {$urandom, $urandom} : pick_ref();
      m.nref = $urandom_range(0, 2) == 0 ? m.oref : {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) m.nref = pick_ref();
      m.side = $urandom_range(0, 15) == 0 ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      m.price = m.side[0] ? $urandom_range(130, 170) : $urandom_range(100, 140);
      m.qty = $urandom_range(1, 500);
      m.ts = 48'({$urandom, $urandom});
      k = $urandom_range(0, 29);
      if (k == 0) m.price = 0;
      if (k == 1) m.qty = 0;
      if (k == 2) m.price = $urandom;
      if (k == 3) m.qty = $urandom;
      if (k == 4) m.qty = 32'hFFFF_FFFF - $urandom_range(0, 3);
      return m;
   endfunction

   row_type rows[$];
   initial begin
      msg_type m;
      rows = '{
         '{'{OP_CLOCK, 0, 0, 0, 0, 0, 0}, 1, STS_OK},
         '{'{3'd7, '1, '1, 3, '1, '1, '1}, 1, STS_OK},
         '{'{OP_ADD, 1, 0, 2, 5, 5, 1}, 1, STS_BAD_SIDE},
         '{'{OP_ADD, 1, 0, 3, 0, 0, 2}, 1, STS_BAD_SIDE},
         '{'{OP_ADD, 1, 0, 0, 0, 5, 3}, 1, STS_ZERO_PRICE},
         '{'{OP_ADD, 1, 0, 1, 5, 0, 4}, 1, STS_ZERO_QTY},
         '{'{OP_EXEC, 1, 0, 0, 5, 5, 5}, 1, STS_NOT_FOUND},
         '{'{OP_DELETE, 1, 0, 0, 0, 0, 6}, 1, STS_NOT_FOUND},
         '{'{OP_REPLACE, '1, 2, 0, 5, 5, 7}, 1, STS_NOT_FOUND},
         '{'{OP_ADD, 1, 0, 0, 100, 10, 8}, 0, STS_OK},
         '{'{OP_ADD, 2, 0, 1, '1, '1, 9}, 0, STS_OK},
         '{'{OP_ADD, 1, 0, 1, 200, 3, 10}, 0, STS_OK},
         '{'{OP_ADD, 3, 0, 1, '1, 1, 11}, 0, STS_OK},
         '{'{OP_EXEC, 1, 0, 0, 0, 0, 12}, 0, STS_OK},
         '{'{OP_EXEC, 1, 0, 0, 0, 11, 13}, 0, STS_OK},
         '{'{OP_EXEC, 1, 0, 0, 0, 4, 14}, 0, STS_OK},
         '{'{OP_REPLACE, 1, 2, 0, 101, 6, 15}, 0, STS_OK},
         '{'{OP_REPLACE, 1, '1, 0, 0, 6, 16}, 0, STS_OK},
         '{'{OP_REPLACE, 1, '1, 0, 101, 0, 17}, 0, STS_OK},
         '{'{OP_REPLACE, 1, 9, 0, 101, 6, 18}, 0, STS_OK},
         '{'{OP_REPLACE, 9, 9, 1, 101, 20, 19}, 0, STS_OK},
         '{'{OP_DELETE, 2, 0, 0, 0, 0, 20}, 0, STS_OK},
         '{'{OP_ADD, 0, 0, 1, 1, 1, 21}, 0, STS_OK},
         '{'{OP_DELETE, 9, 0, 0, 0, 0, 22}, 0, STS_OK},
         '{'{OP_DELETE, 0, 0, 0, 0, 0, 23}, 0, STS_OK}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (rows[i]) send_message(rows[i].m, rows[i].typed, rows[i].st);
      repeat (175) send_message(random_message(), 0, STS_OK);
      // fill the book until the bid and ask levels and the order table run out
      for (int n = 0; n < 1100; n++) begin
         m.op = OP_ADD;
         m.oref = 64'h1000_0000_0000 + n;
         m.nref = 0;
         m.side = n[0];
         m.price = (n < 600) ? 5000 + n / 2 : 5000 + (n % 50);
         m.qty = 1;
         m.ts = 48'({$urandom, $urandom});
         send_message(m, 0, STS_OK);
      end
      repeat (100) begin
         m = random_message();
         if ($urandom_range(0, 1)) begin
            m.op = OP_DELETE;
            m.oref = pick_ref();
         end
         send_message(m, 0, STS_OK);
      end
      req_tvalid = 0;
      while (expected_books.size() != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
      $display("%0d messages sent, %0d results checked (%0d ok, %0d table full)",
               sent, checked, ok_seen, full_seen);
      if (errors == 0 && expected_books.size() == 0)
         $display("limit_order_book_update_core test passed");
      else
         $display("limit_order_book_update_core test failed");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("limit_order_book_update_core test failed");
      $finish;
   end

endmodule
